// ===== sv/button_edge_and_double_click_assert.svh =====
// assertion macros for the button edge and double click block
// used by the top level only; the checking forms drop out under SYNTHESIS
`ifndef BUTTON_EDGE_AND_DOUBLE_CLICK_ASSERT_SVH
`define BUTTON_EDGE_AND_DOUBLE_CLICK_ASSERT_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define BEDC_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");
// condition holds in the cycle after the trigger
`define BEDC_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");
`else
`define BEDC_ASSERT_NOW(label, clk, rst, trig, cond)
`define BEDC_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif

`endif

// ===== sv/bedc_pkg.sv =====
// shared constants and types for the button edge and double click block
// no dependencies; used by every module of the block
package bedc_pkg;

   // number of button lanes, and how many of them have an input level
   localparam int BUTTONS   = 3;
   localparam int IN_LEVELS = 3;

   localparam int TICK_W = 32;
   localparam int POS_W  = 16;
   localparam int MOVE_W = 17;
   localparam int CNT_W  = 2;
   localparam int EV_W   = 3;

   localparam logic [TICK_W-1:0] WINDOW_RESET = 32'd500;

   // button event codes
   localparam logic [EV_W-1:0] EV_NONE = 3'd0;
   localparam logic [EV_W-1:0] EV_DOWN = 3'd1;
   localparam logic [EV_W-1:0] EV_UP   = 3'd2;
   localparam logic [EV_W-1:0] EV_HELD = 3'd3;
   localparam logic [EV_W-1:0] EV_DBL  = 3'd4;

   // request tdata bit positions
   localparam int REQ_W      = 72;
   localparam int REQ_TICK_LO = 3;
   localparam int REQ_X_LO    = REQ_TICK_LO + TICK_W;
   localparam int REQ_Y_LO    = REQ_X_LO + POS_W;

   localparam int RSP_W = 48;

   // result transaction, last field in the lowest bits
   typedef struct packed {
      logic [4:0]              pad;
      logic signed [MOVE_W-1:0] move_y;
      logic signed [MOVE_W-1:0] move_x;
      logic [EV_W-1:0]          middle_event;
      logic [EV_W-1:0]          right_event;
      logic [EV_W-1:0]          left_event;
   } rsp_type;

endpackage

// ===== sv/bedc_lane.sv =====
// one button lane: edge classification, click counter and first press tick
// depends on bedc_pkg
module bedc_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic                          level,
   input  logic [bedc_pkg::TICK_W-1:0]   now_tick,
   input  logic [bedc_pkg::TICK_W-1:0]   window,
   output logic [bedc_pkg::EV_W-1:0]     event_code
);

   logic                          level_ff, level_in;
   logic [bedc_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [bedc_pkg::TICK_W-1:0]   start_ff, start_in;
   logic [bedc_pkg::TICK_W-1:0]   elapsed;
   logic [bedc_pkg::CNT_W-1:0]    base;
   logic [bedc_pkg::EV_W-1:0]     edge_code;
   logic                          expired;
   logic                          in_window;

   // classify against the previous level
   always_comb begin
      case ({level_ff, level})
         2'b01:   edge_code = bedc_pkg::EV_DOWN;
         2'b10:   edge_code = bedc_pkg::EV_UP;
         2'b11:   edge_code = bedc_pkg::EV_HELD;
         default: edge_code = bedc_pkg::EV_NONE;
      endcase
   end

   // wrapping elapsed time since the first press
   assign elapsed   = now_tick - start_ff;
   assign expired   = (elapsed >= window);
   assign in_window = (elapsed <= window);

   // counter and event update
   always_comb begin
      level_in   = level;
      count_in   = count_ff;
      start_in   = start_ff;
      event_code = edge_code;
      base       = count_ff;
      if (edge_code == bedc_pkg::EV_DOWN) begin
         if (count_ff == 2'd1 && expired) begin
            base = '0;
         end
         count_in = base + 2'd1;
         if (base == '0) begin
            start_in = now_tick;
         end
      end else if (edge_code == bedc_pkg::EV_UP) begin
         if (count_ff == 2'd1) begin
            if (expired) begin
               count_in = '0;
            end
         end else if (count_ff == 2'd2) begin
            if (in_window) begin
               event_code = bedc_pkg::EV_DBL;
            end
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         count_ff <= '0;
         start_ff <= '0;
      end else if (take) begin
         level_ff <= level_in;
         count_ff <= count_in;
         start_ff <= start_in;
      end
   end

endmodule

// ===== sv/bedc_motion.sv =====
// cursor motion since the previous sample
// depends on bedc_pkg
module bedc_motion (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic signed [bedc_pkg::POS_W-1:0]    cursor_x,
   input  logic signed [bedc_pkg::POS_W-1:0]    cursor_y,
   output logic signed [bedc_pkg::MOVE_W-1:0]   move_x,
   output logic signed [bedc_pkg::MOVE_W-1:0]   move_y
);

   logic signed [bedc_pkg::POS_W-1:0] prev_x_ff, prev_x_in;
   logic signed [bedc_pkg::POS_W-1:0] prev_y_ff, prev_y_in;

   // sign-extended differences
   assign move_x = {cursor_x[bedc_pkg::POS_W-1], cursor_x}
                 - {prev_x_ff[bedc_pkg::POS_W-1], prev_x_ff};
   assign move_y = {cursor_y[bedc_pkg::POS_W-1], cursor_y}
                 - {prev_y_ff[bedc_pkg::POS_W-1], prev_y_ff};

   assign prev_x_in = cursor_x;
   assign prev_y_in = cursor_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else if (take) begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

endmodule

// ===== sv/bedc_merge.sv =====
// merge stage: collects lane events and motion into the result register
// with a skid entry so input and output stall independently; uses bedc_pkg
module bedc_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bedc_pkg::rsp_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output bedc_pkg::rsp_type   out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   bedc_pkg::rsp_type main_ff, main_in;
   bedc_pkg::rsp_type skid_ff, skid_in;
   logic              main_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign main_free = out_ready || !main_valid_ff;

   // next state of the two entries
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid && in_ready) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== sv/button_edge_and_double_click.sv =====
// button edge classifier and double click detector, top level
// each accepted sample is registered into the result buffer, which drives rsp_tvalid
// throughput: one sample per cycle while req_tready is high; lane state updates in the accepting cycle
// a two-entry result buffer keeps req_tready high while one result is stalled
// reset clears levels, click counts, first press ticks, cursor history, buffer
// and loads the double click window with 500
module button_edge_and_double_click (
   input  logic                              clock,
   input  logic                              reset,
   // sample transactions
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // left_level, right_level, middle_level, now_tick[31:0], cursor_x[15:0],
   // cursor_y[15:0], zero fill
   input  logic [bedc_pkg::REQ_W-1:0]        req_tdata,
   // result transactions
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // left_event[2:0], right_event[2:0], middle_event[2:0], move_x[16:0],
   // move_y[16:0], zero fill
   output logic [bedc_pkg::RSP_W-1:0]        rsp_tdata,
   // window register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bedc_pkg::TICK_W-1:0]       csr_data
);

   `include "button_edge_and_double_click_assert.svh"

   logic [bedc_pkg::TICK_W-1:0]        window_ff, window_in;
   logic                               take;
   logic [bedc_pkg::TICK_W-1:0]        now_tick;
   logic signed [bedc_pkg::POS_W-1:0]  cursor_x, cursor_y;
   logic [bedc_pkg::BUTTONS-1:0]       levels;
   logic [bedc_pkg::EV_W-1:0]          lane_ev [bedc_pkg::BUTTONS];
   logic [bedc_pkg::EV_W-1:0]          out_ev [bedc_pkg::IN_LEVELS];
   bedc_pkg::rsp_type                  merged;
   bedc_pkg::rsp_type                  rsp_word;
   logic                               merge_ready;

   // configuration register, always ready
   assign csr_ready = 1'b1;
   assign window_in = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= bedc_pkg::WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         window_ff <= window_in;
      end
   end

   // request unpacking
   assign take       = req_tvalid && req_tready;
   assign req_tready = merge_ready;
   assign now_tick   = req_tdata[bedc_pkg::REQ_TICK_LO +: bedc_pkg::TICK_W];
   assign cursor_x   = req_tdata[bedc_pkg::REQ_X_LO +: bedc_pkg::POS_W];
   assign cursor_y   = req_tdata[bedc_pkg::REQ_Y_LO +: bedc_pkg::POS_W];

   // button lanes; lanes past the wired inputs always see released
   for (genvar i = 0; i < bedc_pkg::BUTTONS; i++) begin : g_lane
      if (i < bedc_pkg::IN_LEVELS) begin : g_wired
         assign levels[i] = req_tdata[i];
      end else begin : g_idle
         assign levels[i] = 1'b0;
      end
      bedc_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .take       (take),
         .level      (levels[i]),
         .now_tick   (now_tick),
         .window     (window_ff),
         .event_code (lane_ev[i])
      );
   end

   // events for the reported buttons; missing lanes report none
   for (genvar j = 0; j < bedc_pkg::IN_LEVELS; j++) begin : g_ev
      if (j < bedc_pkg::BUTTONS) begin : g_have
         assign out_ev[j] = lane_ev[j];
      end else begin : g_none
         assign out_ev[j] = bedc_pkg::EV_NONE;
      end
   end

   bedc_motion u_motion (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .cursor_x (cursor_x),
      .cursor_y (cursor_y),
      .move_x   (merged.move_x),
      .move_y   (merged.move_y)
   );

   assign merged.pad          = '0;
   assign merged.left_event   = out_ev[0];
   assign merged.right_event  = out_ev[1];
   assign merged.middle_event = out_ev[2];

   bedc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (merge_ready),
      .in_data   (merged),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_word)
   );

   assign rsp_tdata = rsp_word;

   // an accepted sample always leaves a result pending
   `BEDC_ASSERT_NEXT(a_accept_gives_result, clock, reset, take, rsp_tvalid)
   // a stalled input side means a result is waiting
   `BEDC_ASSERT_NOW(a_stall_has_result, clock, reset, !req_tready, rsp_tvalid && !$past(rsp_tready))
   // no event code beyond double click
   `BEDC_ASSERT_NOW(a_event_range, clock, reset, rsp_tvalid,
      rsp_word.left_event <= bedc_pkg::EV_DBL && rsp_word.right_event <= bedc_pkg::EV_DBL
      && rsp_word.middle_event <= bedc_pkg::EV_DBL)

endmodule

// ===== tb/sv/tb_button_edge_and_double_click.sv =====
`timescale 1ns / 100ps
// self-checking testbench for button_edge_and_double_click
// depends on bedc_pkg and the block's top level; holds its own click predictor
module tb_button_edge_and_double_click;
   import bedc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   // tracks button lanes and cursor history, keeps the results still owed by the block
   class click_scoreboard;
      bit [TICK_W-1:0] window;
      bit [2:0]        last_levels;
      bit [CNT_W-1:0]  clicks [3];
      bit [TICK_W-1:0] press_tick [3];
      bit [POS_W-1:0]  last_x;
      bit [POS_W-1:0]  last_y;
      rsp_type         owed [$];
      int              errors;
      int              mismatches;

      function new();
         window      = WINDOW_RESET;
         last_levels = '0;
         last_x      = '0;
         last_y      = '0;
         foreach (clicks[b]) begin
            clicks[b]     = '0;
            press_tick[b] = '0;
         end
         errors     = 0;
         mismatches = 0;
      endfunction

      // work out the result of one accepted sample transaction
      function void note_sample(logic [2:0] levels, logic [TICK_W-1:0] tick,
                                logic [POS_W-1:0] x, logic [POS_W-1:0] y);
         rsp_type         want;
         logic [EV_W-1:0] ev [3];
         logic [TICK_W-1:0] elapsed;
         logic [CNT_W-1:0]  cnt;
         int b;
         for (b = 0; b < 3; b++) begin
            if (levels[b])
               ev[b] = last_levels[b] ? EV_HELD : EV_DOWN;
            else
               ev[b] = last_levels[b] ? EV_UP : EV_NONE;
            elapsed = tick - press_tick[b];
            cnt     = clicks[b];
            if (ev[b] == EV_DOWN) begin
               // a stale single press starts over
               if (cnt == 2'd1 && elapsed >= window)
                  cnt = '0;
               cnt = cnt + 2'd1;
               if (cnt == 2'd1)
                  press_tick[b] = tick;
            end else if (ev[b] == EV_UP) begin
               if (cnt == 2'd1) begin
                  if (elapsed >= window)
                     cnt = '0;
               end else if (cnt == 2'd2) begin
                  // second release closes the pair, inside the window or not
                  if (elapsed <= window)
                     ev[b] = EV_DBL;
                  cnt = '0;
               end
            end
            clicks[b] = cnt;
         end
         last_levels       = levels;
         want              = '0;
         want.left_event   = ev[0];
         want.right_event  = ev[1];
         want.middle_event = ev[2];
         want.move_x       = {x[POS_W-1], x} - {last_x[POS_W-1], last_x};
         want.move_y       = {y[POS_W-1], y} - {last_y[POS_W-1], last_y};
         last_x            = x;
         last_y            = y;
         owed.push_back(want);
      endfunction

      function void compare(string field, logic [MOVE_W-1:0] want, logic [MOVE_W-1:0] got);
         if (got !== want) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on %s: expected %0h, got %0h", field, want, got);
         end
      endfunction

      // compare one accepted result transaction with the oldest one owed
      function void check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("result %h arrived with nothing expected", got);
            return;
         end
         want = owed.pop_front();
         compare("left_event", MOVE_W'(want.left_event), MOVE_W'(got.left_event));
         compare("right_event", MOVE_W'(want.right_event), MOVE_W'(got.right_event));
         compare("middle_event", MOVE_W'(want.middle_event), MOVE_W'(got.middle_event));
         compare("move_x", want.move_x, got.move_x);
         compare("move_y", want.move_y, got.move_y);
         compare("zero fill", MOVE_W'(want.pad), MOVE_W'(got.pad));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_valid;
   logic              csr_ready;
   logic [TICK_W-1:0] csr_data;

   click_scoreboard   sb;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                cycles;

   // running state of the random sample stream
   logic [2:0]        rnd_levels;
   logic [TICK_W-1:0] rnd_tick;
   logic [POS_W-1:0]  rnd_x;
   logic [POS_W-1:0]  rnd_y;

   button_edge_and_double_click u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_type'(rsp_tdata));
   end

   // run length guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one sample transaction, entered and left at a falling edge
   task automatic send_sample(logic [2:0] levels, logic [TICK_W-1:0] tick,
                              logic [POS_W-1:0] x, logic [POS_W-1:0] y);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, y, x, tick, levels};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_sample(levels, tick, x, y);
      @(negedge clock);
   endtask

   // stop sending and wait until every owed result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.owed.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_window(logic [TICK_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.window = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly plausible press/release streams with a drifting tick and cursor
   task automatic random_samples(int count);
      int i;
      int b;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            for (b = 0; b < 3; b++)
               if ($urandom_range(0, 99) < 35)
                  rnd_levels[b] = ~rnd_levels[b];
         end else begin
            rnd_levels = 3'($urandom);
         end
         case ($urandom_range(0, 9))
            0:       rnd_tick = $urandom;
            1:       rnd_tick = rnd_tick + $urandom_range(0, 3000);
            default: rnd_tick = rnd_tick + $urandom_range(0, 700);
         endcase
         if ($urandom_range(0, 4) == 0)
            rnd_x = POS_W'($urandom);
         else
            rnd_x = rnd_x + POS_W'($urandom_range(0, 64)) - 16'd32;
         if ($urandom_range(0, 4) == 0)
            rnd_y = POS_W'($urandom);
         else
            rnd_y = rnd_y + POS_W'($urandom_range(0, 64)) - 16'd32;
         send_sample(rnd_levels, rnd_tick, rnd_x, rnd_y);
      end
   endtask

   initial begin
      sb            = new();
      cycles        = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      send_idle_pct = 21;
      recv_idle_pct = 73;
      rnd_levels    = '0;
      rnd_tick      = '0;
      rnd_x         = '0;
      rnd_y         = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset window: double click on the window boundary, cursor extremes
      send_sample(3'b000, 32'd0, 16'h0000, 16'h0000);
      send_sample(3'b001, 32'd100, 16'h7FFF, 16'h8000);
      send_sample(3'b000, 32'd150, 16'h8000, 16'h7FFF);
      send_sample(3'b001, 32'd300, 16'h7FFF, 16'h8000);
      send_sample(3'b000, 32'd600, 16'hFFFF, 16'hFFFF);
      // lanes pressed at different samples, then every lane up together
      send_sample(3'b110, 32'd1000, 16'h0001, 16'hFFFE);
      send_sample(3'b111, 32'd1100, 16'h0001, 16'hFFFE);
      send_sample(3'b000, 32'd1700, 16'h0000, 16'h0000);
      // stale first press restarts the pair, late second release is a plain up
      send_sample(3'b010, 32'd1800, 16'h0000, 16'h0000);
      send_sample(3'b000, 32'd1850, 16'h0000, 16'h0000);
      send_sample(3'b010, 32'd2301, 16'h0000, 16'h0000);
      send_sample(3'b000, 32'd2350, 16'h0000, 16'h0000);
      send_sample(3'b010, 32'd2400, 16'h0000, 16'h0000);
      send_sample(3'b000, 32'd2902, 16'h0000, 16'h0000);
      // double click across the tick wrap
      send_sample(3'b100, 32'hFFFF_FF00, 16'h1234, 16'h4321);
      send_sample(3'b000, 32'hFFFF_FF10, 16'h1234, 16'h4321);
      send_sample(3'b100, 32'h0000_0050, 16'h1234, 16'h4321);
      send_sample(3'b000, 32'h0000_00F0, 16'h1234, 16'h4321);

      // zero window: pairs never complete
      write_window(32'd0);
      send_sample(3'b001, 32'd5000, 16'h0000, 16'h0000);
      send_sample(3'b000, 32'd5000, 16'h0000, 16'h0000);
      send_sample(3'b001, 32'd5000, 16'h0000, 16'h0000);
      send_sample(3'b000, 32'd5001, 16'h0000, 16'h0000);

      // all-ones window: any gap counts, even one that wraps backwards
      write_window(32'hFFFF_FFFF);
      send_sample(3'b001, 32'd10, 16'h0000, 16'h0000);
      send_sample(3'b000, 32'd20, 16'h0000, 16'h0000);
      send_sample(3'b001, 32'h8000_0000, 16'h0000, 16'h0000);
      send_sample(3'b000, 32'd5, 16'h0000, 16'h0000);

      // random part, one window and one idling pattern per phase
      write_window($urandom_range(200, 600));
      random_samples(660);
      send_idle_pct = 73;
      recv_idle_pct = 21;
      write_window(32'hFFFF_FFFF);
      random_samples(660);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_window(WINDOW_RESET);
      random_samples(660);

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.owed.size() != 0) begin
         sb.errors += sb.owed.size();
         $display("%0d results never arrived", sb.owed.size());
      end
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
